// ===== src/isl_pkg.sv =====
package isl_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_SHEAR_FACTOR  = 3'd0;
    localparam logic [2:0] CFG_OFFSET_BIAS   = 3'd1;
    localparam logic [2:0] CFG_SOURCE_LENGTH = 3'd2;
    localparam logic [2:0] CFG_TARGET_LENGTH = 3'd3;
    localparam logic [2:0] CFG_LINE_TOTAL    = 3'd4;
    localparam logic [2:0] CFG_RUN_BACKWARD  = 3'd5;
    localparam logic [2:0] CFG_INTERPOLATE   = 3'd6;
    localparam logic [2:0] CFG_PIXEL_BYTES   = 3'd7;

    // Blend arithmetic: 12-bit fraction, round to nearest
    localparam int         FRAC_BITS  = 12;
    localparam logic [12:0] FRAC_ONE  = 13'd4096;
    localparam logic [11:0] ROUND_HALF = 12'd2048;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        pixel_t      pixel;
        logic        end_of_line;
    } item_t;

    typedef struct packed {
        pixel_t      pixel;
        logic [12:0] position;
        logic        last;
    } result_t;

endpackage

// ===== src/isl_blend.sv =====
module isl_blend (
    input  logic [7:0]  prev_px,
    input  logic [7:0]  cur_px,
    input  logic [11:0] frac,
    input  logic        trail_from_cur,
    output logic [7:0]  mixed_px,
    output logic [7:0]  trail_px
);

    logic [12:0] inv_frac;
    logic [19:0] prev_term;
    logic [20:0] cur_term;
    logic [20:0] mix_sum;
    logic [7:0]  trail_src;
    logic [19:0] trail_term;
    logic [20:0] trail_sum;

    assign inv_frac  = isl_pkg::FRAC_ONE - {1'b0, frac};
    assign prev_term = 20'(prev_px) * 20'(frac);
    assign cur_term  = 21'(cur_px) * 21'(inv_frac);
    assign mix_sum   = 21'(prev_term) + cur_term + 21'(isl_pkg::ROUND_HALF);
    assign mixed_px  = mix_sum[isl_pkg::FRAC_BITS +: 8];

    // trailing pixel blends the last landed pixel against black
    assign trail_src  = trail_from_cur ? cur_px : prev_px;
    assign trail_term = 20'(trail_src) * 20'(frac);
    assign trail_sum  = 21'(trail_term) + 21'(isl_pkg::ROUND_HALF);
    assign trail_px   = trail_sum[isl_pkg::FRAC_BITS +: 8];

endmodule

// ===== src/image_shear_line_interpolator_core.sv =====
// A pixel beat is registered in the input stage, then its results in the result pair.
// Throughput: one pixel beat per cycle while the output is not stalled and no reload is
// pending; a pixel that yields a placed and a trailing pixel takes two output beats, so
// the following pixel holds in the input stage until the second beat leaves.
// Reset (rst_n, asynchronous, active low) clears the registers to their defaults, empties
// both stages and zeroes the line and column counts; after any register write, and when a
// backward pass wraps its line count, the line product is reloaded through the multiplier
// while the input stage holds.
module image_shear_line_interpolator_core #(
    parameter int MAX_SOURCE = 4096,
    parameter int MAX_TARGET = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // source pixel channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        end_of_line,
    // placed pixel channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [12:0] position,
    output logic        last_of_run
);

    // Length limits, worked out at elaboration
    localparam logic [16:0] SRC_LIM = 17'(MAX_SOURCE);
    localparam logic [16:0] TGT_LIM = 17'(MAX_TARGET - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] shear_factor_reg;
    logic [11:0] offset_bias_reg;
    logic [12:0] source_length_reg;
    logic [12:0] target_length_reg;
    logic [12:0] line_total_reg;
    logic        run_backward_reg;
    logic        interpolate_reg;
    logic [1:0]  pixel_bytes_reg;

    logic        cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shear_factor_reg  <= '0;
            offset_bias_reg   <= '0;
            source_length_reg <= 13'd1;
            target_length_reg <= 13'd1;
            line_total_reg    <= '0;
            run_backward_reg  <= 1'b0;
            interpolate_reg   <= 1'b1;
            pixel_bytes_reg   <= 2'd3;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                isl_pkg::CFG_SHEAR_FACTOR:  shear_factor_reg  <= cfg_data;
                isl_pkg::CFG_OFFSET_BIAS:   offset_bias_reg   <= cfg_data[11:0];
                isl_pkg::CFG_SOURCE_LENGTH: source_length_reg <= cfg_data[12:0];
                isl_pkg::CFG_TARGET_LENGTH: target_length_reg <= cfg_data[12:0];
                isl_pkg::CFG_LINE_TOTAL:    line_total_reg    <= cfg_data[12:0];
                isl_pkg::CFG_RUN_BACKWARD:  run_backward_reg  <= cfg_data[0];
                isl_pkg::CFG_INTERPOLATE:   interpolate_reg   <= cfg_data[0];
                isl_pkg::CFG_PIXEL_BYTES:   pixel_bytes_reg   <= cfg_data[1:0];
            endcase
        end
    end

    // Clamp the lengths to what the parameters allow
    logic [16:0] slen_wide;
    logic [16:0] tlen_wide;
    logic [12:0] slen;
    logic [12:0] tlen;
    logic        mix;

    assign slen_wide = ({4'b0, source_length_reg} > SRC_LIM) ? SRC_LIM
                                                             : {4'b0, source_length_reg};
    assign tlen_wide = ({4'b0, target_length_reg} > TGT_LIM) ? TGT_LIM
                                                             : {4'b0, target_length_reg};
    assign slen = slen_wide[12:0];
    assign tlen = tlen_wide[12:0];

    // Blending needs all three channels; otherwise copy
    assign mix = interpolate_reg && (pixel_bytes_reg == 2'd3);

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic          s1_valid_reg;
    isl_pkg::item_t s1_reg;
    logic [1:0]    out_count_reg;
    isl_pkg::result_t res0_reg;
    isl_pkg::result_t res1_reg;
    logic          reload_pend_reg;

    logic in_accept;
    logic out_accept;
    logic out_free;
    logic s1_move;

    assign out_valid  = (out_count_reg != 2'd0);
    assign out_accept = out_valid && !out_stall;
    // the result pair can take a new item once the last beat leaves
    assign out_free   = (out_count_reg == 2'd0) || ((out_count_reg == 2'd1) && out_accept);
    // hold the pixel while the line product is being reloaded
    assign s1_move    = s1_valid_reg && out_free && !reload_pend_reg;
    assign in_stall   = s1_valid_reg && !s1_move;
    assign in_accept  = in_valid && !in_stall;

    // Input register: hold the beat until the result side has room and no reload is pending
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg.pixel.red   <= red;
            s1_reg.pixel.green <= green;
            s1_reg.pixel.blue  <= blue;
            s1_reg.end_of_line <= end_of_line;
        end
    end

    // ------------------------------------------------------------------
    // Line state. The product base * shear_factor is kept for the current
    // line and stepped by one shear_factor at each line end, so no
    // multiplication sits between two lines. After a register write, and
    // when a backward pass wraps from the top line index back to zero, the
    // product is reloaded through the multiplier; a pixel in the input
    // stage waits for it.
    // ------------------------------------------------------------------
    logic [12:0]      line_index_reg;
    logic [11:0]      column_reg;
    logic [28:0]      prod_reg;
    isl_pkg::pixel_t  prev_reg;

    logic [12:0] line_base;
    logic [28:0] reload_prod;
    logic [28:0] prod_step;

    assign line_base   = run_backward_reg
                       ? ((line_total_reg >= line_index_reg) ? (line_total_reg - line_index_reg)
                                                             : 13'd0)
                       : line_index_reg;
    assign reload_prod = 29'(line_base) * 29'(shear_factor_reg);

    // next line's product: forward adds, backward subtracts until the base hits zero
    always_comb
    begin
        if (run_backward_reg)
        begin
            prod_step = (line_total_reg > line_index_reg)
                      ? (prod_reg - 29'(shear_factor_reg)) : 29'd0;
        end
        else
        begin
            prod_step = (line_index_reg == '1) ? 29'd0 : (prod_reg + 29'(shear_factor_reg));
        end
    end

    // Placement of the pixel in the stage and of a trailing pixel
    logic [14:0] start_offset;
    logic [14:0] pix_pos;
    logic [14:0] trail_pos;
    logic [11:0] fraction;
    logic        landed;
    logic        trail;

    assign start_offset = {2'b0, prod_reg[28:16]} - {3'b0, offset_bias_reg};
    assign fraction     = prod_reg[15:4];
    assign pix_pos      = start_offset + {3'b0, column_reg};
    assign trail_pos    = start_offset + {2'b0, slen};
    assign landed       = !pix_pos[14] && (pix_pos[13:0] < {1'b0, tlen});
    assign trail        = s1_reg.end_of_line && mix && (fraction != 12'd0)
                       && !trail_pos[14] && (trail_pos[13:0] < {1'b0, tlen});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_index_reg  <= '0;
            column_reg      <= '0;
            prod_reg        <= '0;
            reload_pend_reg <= 1'b0;
            prev_reg        <= '0;
        end
        else if (cfg_write)
        begin
            // a register write starts over from line zero
            line_index_reg  <= '0;
            column_reg      <= '0;
            reload_pend_reg <= 1'b1;
            prev_reg        <= '0;
        end
        else if (reload_pend_reg)
        begin
            prod_reg        <= reload_prod;
            reload_pend_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            if (s1_reg.end_of_line)
            begin
                // close the line: advance, rewind the column, drop the history
                line_index_reg <= line_index_reg + 13'd1;
                column_reg     <= '0;
                prod_reg       <= prod_step;
                prev_reg       <= '0;
                // backward base jumps back to line_total: reload through the multiplier
                if (run_backward_reg && (line_index_reg == '1))
                begin
                    reload_pend_reg <= 1'b1;
                end
            end
            else
            begin
                column_reg <= column_reg + 12'd1;
                if (landed && mix)
                begin
                    prev_reg <= s1_reg.pixel;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Blend datapath, one unit per channel
    // ------------------------------------------------------------------
    isl_pkg::pixel_t mixed_px;
    isl_pkg::pixel_t trail_px;
    logic            trail_from_cur;

    // a pixel that lands under blending becomes the history for the trailer
    assign trail_from_cur = landed && mix;

    isl_blend u_blend_red (
        .prev_px        (prev_reg.red),
        .cur_px         (s1_reg.pixel.red),
        .frac           (fraction),
        .trail_from_cur (trail_from_cur),
        .mixed_px       (mixed_px.red),
        .trail_px       (trail_px.red)
    );

    isl_blend u_blend_green (
        .prev_px        (prev_reg.green),
        .cur_px         (s1_reg.pixel.green),
        .frac           (fraction),
        .trail_from_cur (trail_from_cur),
        .mixed_px       (mixed_px.green),
        .trail_px       (trail_px.green)
    );

    isl_blend u_blend_blue (
        .prev_px        (prev_reg.blue),
        .cur_px         (s1_reg.pixel.blue),
        .frac           (fraction),
        .trail_from_cur (trail_from_cur),
        .mixed_px       (mixed_px.blue),
        .trail_px       (trail_px.blue)
    );

    // ------------------------------------------------------------------
    // Result pair: up to two results per pixel, shown one beat at a time
    // ------------------------------------------------------------------
    isl_pkg::pixel_t  plain_px;
    isl_pkg::result_t main_res;
    isl_pkg::result_t trail_res;
    isl_pkg::result_t res0_next;
    logic [1:0]       res_n;

    // plain copy: red always passes; channels beyond pixel_bytes read as zero
    assign plain_px.red   = s1_reg.pixel.red;
    assign plain_px.green = (pixel_bytes_reg >= 2'd2) ? s1_reg.pixel.green : 8'd0;
    assign plain_px.blue  = (pixel_bytes_reg == 2'd3) ? s1_reg.pixel.blue  : 8'd0;

    assign res_n = {1'b0, landed} + {1'b0, trail};

    assign main_res.pixel    = mix ? mixed_px : plain_px;
    assign main_res.position = pix_pos[12:0];
    assign main_res.last     = !trail;

    assign trail_res.pixel    = trail_px;
    assign trail_res.position = trail_pos[12:0];
    assign trail_res.last     = 1'b1;

    assign res0_next = landed ? main_res : trail_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_count_reg <= 2'd0;
        end
        else
        begin
            priority if (s1_move && (res_n != 2'd0))
            begin
                out_count_reg <= res_n;
            end
            else if (out_accept)
            begin
                out_count_reg <= out_count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (s1_move && (res_n != 2'd0))
        begin
            res0_reg <= res0_next;
            res1_reg <= trail_res;
        end
        else if (out_accept)
        begin
            // advance the trailer into the shown slot
            res0_reg <= res1_reg;
        end
    end

    assign out_red     = res0_reg.pixel.red;
    assign out_green   = res0_reg.pixel.green;
    assign out_blue    = res0_reg.pixel.blue;
    assign position    = res0_reg.position;
    assign last_of_run = res0_reg.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_count_reg != 2'd3)
        else $error("result pair holds more than two beats");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_count_reg == 2'd2) |-> (!res0_reg.last && res1_reg.last))
        else $error("first of two results marked last, or trailer not marked last");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> ((line_index_reg == 13'd0) && (column_reg == 12'd0)
                       && (prev_reg == '0) && reload_pend_reg))
        else $error("register write did not restart the line state");

    a_eol_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_reg.end_of_line) |=> ((column_reg == 12'd0) && (prev_reg == '0)))
        else $error("line end did not rewind the column and clear the history");

endmodule
